[hdl/hsl_pkg.sv]
// ----------------------------------------------------------------------------
// hsl_pkg
// Shared constants and types for the HSL to RGB converter pipeline.
// ----------------------------------------------------------------------------
package hsl_pkg;

    // Width of each input field (two's complement)
    localparam int IN_W = 24;

    // Default number of fraction bits
    localparam int FRACTION_BITS_DEF = 16;

    // Register stages from input capture to output register
    localparam int NUM_STAGES = 6;

    // Channel selector for the ramp unit
    typedef logic [1:0] hsl_channel_t;
    localparam hsl_channel_t CH_RED   = 2'd0;
    localparam hsl_channel_t CH_GREEN = 2'd1;
    localparam hsl_channel_t CH_BLUE  = 2'd2;

    // Per-stage load enables, one per pipeline register stage
    typedef struct packed {
        logic capture;  // stage 1: clamp and wrap
        logic mult;     // stage 2: lightness product
        logic mix;      // stage 3: q, p, difference
        logic seg;      // stage 4: ramp segment and slope factor
        logic scale;    // stage 5: slope product
        logic out;      // stage 6: output register
    } hsl_stage_en_t;

endpackage

[hdl/hsl_qp.sv]
// ----------------------------------------------------------------------------
// hsl_qp
// Front half of the pipeline: clamps saturation and lightness, wraps hue,
// and forms q, p and their difference over three register stages.
// ----------------------------------------------------------------------------
module hsl_qp #(
    parameter int FRACTION_BITS = hsl_pkg::FRACTION_BITS_DEF
) (
    input  logic                                aclk,
    input  hsl_pkg::hsl_stage_en_t              stage_en,
    input  logic signed [hsl_pkg::IN_W-1:0]     hue,
    input  logic signed [hsl_pkg::IN_W-1:0]     saturation,
    input  logic signed [hsl_pkg::IN_W-1:0]     lightness,
    output logic        [FRACTION_BITS-1:0]     hue_q,
    output logic        [FRACTION_BITS:0]       p_q,
    output logic        [FRACTION_BITS:0]       q_q,
    output logic        [FRACTION_BITS:0]       d_q
);
    import hsl_pkg::*;

    localparam int F  = FRACTION_BITS;
    localparam int VW = F + 1;
    localparam int CW = ((IN_W > VW) ? IN_W : VW) + 1;
    localparam int PW = 2 * VW + 1;
    localparam int SW = PW - F;

    localparam logic signed [CW-1:0] ONE_C  = CW'(1) << F;
    localparam logic        [VW-1:0] ONE_V  = VW'(1) << F;
    localparam logic        [VW-1:0] HALF_V = VW'(1) << (F - 1);

    // stage 1
    logic [F-1:0]  h1_reg;
    logic [VW-1:0] s1_reg;
    logic [VW-1:0] l1_reg;
    logic [VW-1:0] s_clamp;
    logic [VW-1:0] l_clamp;
    logic signed [CW-1:0] s_ext;
    logic signed [CW-1:0] l_ext;

    // stage 2
    logic [F-1:0]  h2_reg;
    logic [VW-1:0] s2_reg;
    logic [VW-1:0] l2_reg;
    logic          lo2_reg;
    logic [PW-1:0] prod2_reg;
    logic          lo;
    logic [VW:0]   mop;

    // stage 3
    logic [F-1:0]  h3_reg;
    logic [VW-1:0] p3_reg;
    logic [VW-1:0] q3_reg;
    logic [VW-1:0] d3_reg;
    logic [SW-1:0] prod_sh;
    logic [SW-1:0] q_wide;
    logic [SW-1:0] p_wide;
    logic [VW-1:0] q_next;
    logic [VW-1:0] p_next;

    assign s_ext = CW'(saturation);
    assign l_ext = CW'(lightness);

    always_comb begin
        if (s_ext < 0) begin
            s_clamp = '0;
        end else if (s_ext > ONE_C) begin
            s_clamp = ONE_V;
        end else begin
            s_clamp = s_ext[VW-1:0];
        end
        if (l_ext < 0) begin
            l_clamp = '0;
        end else if (l_ext > ONE_C) begin
            l_clamp = ONE_V;
        end else begin
            l_clamp = l_ext[VW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en.capture) begin
            h1_reg <= hue[F-1:0];
            s1_reg <= s_clamp;
            l1_reg <= l_clamp;
        end
    end

    // lower half: l * (1 + s); upper half: l * s, subtracted later
    assign lo  = (l1_reg < HALF_V);
    assign mop = lo ? ({1'b0, ONE_V} + {1'b0, s1_reg}) : {1'b0, s1_reg};

    always_ff @(posedge aclk) begin
        if (stage_en.mult) begin
            h2_reg    <= h1_reg;
            s2_reg    <= s1_reg;
            l2_reg    <= l1_reg;
            lo2_reg   <= lo;
            prod2_reg <= PW'(l1_reg) * PW'(mop);
        end
    end

    assign prod_sh = prod2_reg[PW-1:F];

    always_comb begin
        if (lo2_reg) begin
            q_wide = prod_sh;
        end else begin
            q_wide = SW'(l2_reg) + SW'(s2_reg) - prod_sh;
        end
        q_next = q_wide[VW-1:0];
        p_wide = SW'({l2_reg, 1'b0}) - SW'(q_next);
        p_next = p_wide[VW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (stage_en.mix) begin
            h3_reg <= h2_reg;
            q3_reg <= q_next;
            p3_reg <= p_next;
            d3_reg <= (q_next > p_next) ? (q_next - p_next) : '0;
        end
    end

    assign hue_q = h3_reg;
    assign p_q   = p3_reg;
    assign q_q   = q3_reg;
    assign d_q   = d3_reg;

endmodule

[hdl/hsl_ramp.sv]
// ----------------------------------------------------------------------------
// hsl_ramp
// Piecewise hue ramp for one color channel: segment select, slope product
// and final select with clamp, over three register stages.
// ----------------------------------------------------------------------------
module hsl_ramp #(
    parameter int                    FRACTION_BITS = hsl_pkg::FRACTION_BITS_DEF,
    parameter hsl_pkg::hsl_channel_t CHANNEL       = hsl_pkg::CH_GREEN
) (
    input  logic                         aclk,
    input  hsl_pkg::hsl_stage_en_t       stage_en,
    input  logic [FRACTION_BITS-1:0]     hue,
    input  logic [FRACTION_BITS:0]       p_in,
    input  logic [FRACTION_BITS:0]       q_in,
    input  logic [FRACTION_BITS:0]       d_in,
    output logic [FRACTION_BITS:0]       value
);
    import hsl_pkg::*;

    localparam int F    = FRACTION_BITS;
    localparam int VW   = F + 1;
    localparam int TW   = F + 2;
    localparam int XW   = VW + 3;
    localparam int MW   = 2 * VW;
    localparam int ONE_I   = 1 << F;
    localparam int THIRD_I = ONE_I / 3;
    localparam int TT_I    = 2 * THIRD_I;
    localparam int OFF_I   = (CHANNEL == CH_RED)  ? THIRD_I :
                             (CHANNEL == CH_BLUE) ? -THIRD_I : 0;

    localparam logic signed [TW-1:0] ONE_T = TW'(ONE_I);
    localparam logic signed [TW-1:0] OFF_T = TW'(OFF_I);
    localparam logic        [VW-1:0] ONE_V = VW'(ONE_I);
    localparam logic        [VW-1:0] HALF_V = VW'(ONE_I / 2);
    localparam logic        [VW-1:0] TT_V  = VW'(TT_I);
    localparam logic        [XW-1:0] ONE_X = XW'(ONE_I);

    localparam logic [1:0] SEG_RISE = 2'd0;
    localparam logic [1:0] SEG_HIGH = 2'd1;
    localparam logic [1:0] SEG_FALL = 2'd2;
    localparam logic [1:0] SEG_LOW  = 2'd3;

    logic signed [TW-1:0] t_raw;
    logic signed [TW-1:0] t_wrap;
    logic [VW-1:0] t_u;
    logic [XW-1:0] six_t;
    logic [XW-1:0] six_fall;
    logic [1:0]    seg_next;
    logic [VW-1:0] k_next;

    logic [1:0]    seg4_reg;
    logic [VW-1:0] k4_reg;
    logic [VW-1:0] d4_reg;
    logic [VW-1:0] p4_reg;
    logic [VW-1:0] q4_reg;

    logic [1:0]    seg5_reg;
    logic [MW-1:0] mul5_reg;
    logic [VW-1:0] p5_reg;
    logic [VW-1:0] q5_reg;

    logic [VW+1:0] sum;
    logic [VW-1:0] value_next;
    logic [VW-1:0] value_reg;

    assign t_raw = signed'({2'b00, hue}) + OFF_T;

    always_comb begin
        if (t_raw < 0) begin
            t_wrap = t_raw + ONE_T;
        end else if (t_raw > ONE_T) begin
            t_wrap = t_raw - ONE_T;
        end else begin
            t_wrap = t_raw;
        end
        t_u      = t_wrap[VW-1:0];
        six_t    = (XW'(t_u) << 2) + (XW'(t_u) << 1);
        six_fall = (XW'(TT_V - t_u) << 2) + (XW'(TT_V - t_u) << 1);
        if (six_t < ONE_X) begin
            seg_next = SEG_RISE;
            k_next   = six_t[VW-1:0];
        end else if (t_u < HALF_V) begin
            seg_next = SEG_HIGH;
            k_next   = '0;
        end else if (t_u < TT_V) begin
            seg_next = SEG_FALL;
            k_next   = six_fall[VW-1:0];
        end else begin
            seg_next = SEG_LOW;
            k_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en.seg) begin
            seg4_reg <= seg_next;
            k4_reg   <= k_next;
            d4_reg   <= d_in;
            p4_reg   <= p_in;
            q4_reg   <= q_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en.scale) begin
            seg5_reg <= seg4_reg;
            mul5_reg <= MW'(d4_reg) * MW'(k4_reg);
            p5_reg   <= p4_reg;
            q5_reg   <= q4_reg;
        end
    end

    assign sum = (VW + 2)'(p5_reg) + (VW + 2)'(mul5_reg[MW-1:F]);

    always_comb begin
        case (seg5_reg)
            SEG_RISE, SEG_FALL: begin
                value_next = (sum > (VW + 2)'(ONE_V)) ? ONE_V : sum[VW-1:0];
            end
            SEG_HIGH: begin
                value_next = q5_reg;
            end
            default: begin
                value_next = p5_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stage_en.out) begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

[hdl/hsl_to_rgb_converter.sv]
// ----------------------------------------------------------------------------
// hsl_to_rgb_converter
// HSL to RGB color conversion, fixed point, six-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_* takes one hue/saturation/lightness triple per transfer;
//   master channel m_* returns one red/green/blue triple per input, in order.
//   Throughput is one transfer per cycle while m_tready is high: the lightness
//   multiplier in stage 2 and the three slope multipliers in stage 5 are each
//   fully pipelined.
//   Every stage carries a valid bit; a stage loads whenever it is empty or the
//   stage after it moves, so bubbles collapse and s_tready drops only when
//   all six stages hold data and m_tready is low. A stall holds the output
//   register and loses or repeats nothing.
//   Reset (aresetn low at a clock edge) empties the pipeline; data in flight
//   is dropped and m_tvalid goes low.
//   Hue keeps only its fraction bits; saturation and lightness clamp to
//   zero through one. Outputs run from zero to one inclusive.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter #(
    parameter int FRACTION_BITS = hsl_pkg::FRACTION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // hue [23:0], saturation [47:24], lightness [71:48]
    input  logic [71:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // red [F:0], green [2F+1:F+1], blue [3F+2:2F+2], zero padded to bytes
    output logic [((3 * (FRACTION_BITS + 1) + 7) / 8) * 8 - 1:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready
);
    import hsl_pkg::*;

    localparam int VW = FRACTION_BITS + 1;
    localparam int OW = ((3 * VW + 7) / 8) * 8;
    localparam logic [VW-1:0] ONE_V = VW'(1) << FRACTION_BITS;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] adv;
    hsl_stage_en_t         stage_en;

    logic [FRACTION_BITS-1:0] hue_mid;
    logic [VW-1:0] p_mid;
    logic [VW-1:0] q_mid;
    logic [VW-1:0] d_mid;
    logic [VW-1:0] red;
    logic [VW-1:0] green;
    logic [VW-1:0] blue;

    // advance chain from the output back to the input
    always_comb begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (adv[0]) begin
            valid_next[0] = s_tvalid;
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (adv[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign stage_en = '{capture: adv[0], mult: adv[1], mix: adv[2],
                        seg: adv[3], scale: adv[4], out: adv[5]};

    hsl_qp #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_qp (
        .aclk      (aclk),
        .stage_en  (stage_en),
        .hue       (s_tdata[23:0]),
        .saturation(s_tdata[47:24]),
        .lightness (s_tdata[71:48]),
        .hue_q     (hue_mid),
        .p_q       (p_mid),
        .q_q       (q_mid),
        .d_q       (d_mid)
    );

    hsl_ramp #(
        .FRACTION_BITS(FRACTION_BITS),
        .CHANNEL      (CH_RED)
    ) u_ramp_red (
        .aclk    (aclk),
        .stage_en(stage_en),
        .hue     (hue_mid),
        .p_in    (p_mid),
        .q_in    (q_mid),
        .d_in    (d_mid),
        .value   (red)
    );

    hsl_ramp #(
        .FRACTION_BITS(FRACTION_BITS),
        .CHANNEL      (CH_GREEN)
    ) u_ramp_green (
        .aclk    (aclk),
        .stage_en(stage_en),
        .hue     (hue_mid),
        .p_in    (p_mid),
        .q_in    (q_mid),
        .d_in    (d_mid),
        .value   (green)
    );

    hsl_ramp #(
        .FRACTION_BITS(FRACTION_BITS),
        .CHANNEL      (CH_BLUE)
    ) u_ramp_blue (
        .aclk    (aclk),
        .stage_en(stage_en),
        .hue     (hue_mid),
        .p_in    (p_mid),
        .q_in    (q_mid),
        .d_in    (d_mid),
        .value   (blue)
    );

    assign s_tready = adv[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = OW'({blue, green, red});

    // empty output register means the whole chain advances
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output register");

    // input backpressure only when the first stage is occupied and the output is stalled
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (valid_reg[0] && m_tvalid && !m_tready))
        else $error("s_tready low without a full, stalled pipeline");

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (red <= ONE_V && green <= ONE_V && blue <= ONE_V))
        else $error("color channel above one");

    a_reset_flush: assert property (@(posedge aclk)
        !aresetn |=> (valid_reg == '0))
        else $error("pipeline not emptied by reset");

endmodule
